FILE: hw/rtl/uks_pkg.sv
// shared constants and codes for the unordered key set
package uks_pkg;

   // set geometry
   localparam int CAPACITY  = 16;
   localparam int KEY_WIDTH = 32;

   // item field widths
   localparam int CMD_W    = 2;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   // derived storage widths
   localparam int KEY_BITS = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // stream payload widths
   localparam int REQ_DATA_W = KEY_W;
   localparam int REQ_USER_W = CMD_W;
   localparam int RSP_BITS   = STATUS_W + POS_W + COUNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;

   typedef enum logic [CMD_W-1:0] {
      CMD_CHECK  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_PRESENT = 2'd1,
      ST_FULL    = 2'd2,
      ST_ABSENT  = 2'd3
   } status_type;

endpackage

FILE: hw/rtl/unordered_key_set.sv
// unordered key set: key store memory with a search and shift sequencer
// sequence: clear needs no search and goes straight to the finish state; check and add search
// the stored entries and delete also shifts later ones down, one stored entry per cycle through the read port
// flow: one item at a time, the next item is taken only after the result of the last one is
// registered, and the result waits while an earlier response has not yet been taken
// reset: synchronous, clears the key count and control state; stored keys stay undefined
module unordered_key_set (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [uks_pkg::REQ_DATA_W-1:0] req_tdata,  // key[31:0]
   input  logic [uks_pkg::REQ_USER_W-1:0] req_tuser,  // cmd[1:0]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [uks_pkg::RSP_DATA_W-1:0] rsp_tdata   // status[1:0], position[5:2], count[10:6]
);
   import uks_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_FINISH
   } state_type;

   // key store
   logic [KEY_BITS-1:0] key_mem [CAPACITY];
   logic [KEY_BITS-1:0] rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [KEY_BITS-1:0] wr_data;

   // control and payload registers
   state_type           state_ff,      state_in;
   cmd_type             op_ff,         op_in;
   logic [KEY_BITS-1:0] key_ff,        key_in;
   logic [CNT_W-1:0]    count_ff,      count_in;
   logic [CNT_W-1:0]    issue_ff,      issue_in;
   logic                chk_vld_ff,    chk_vld_in;
   logic [CNT_W-1:0]    chk_idx_ff,    chk_idx_in;
   status_type          res_status_ff, res_status_in;
   logic [CNT_W-1:0]    res_pos_ff,    res_pos_in;
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                rd_more;
   logic                hit;
   logic                last;
   logic [CNT_W-1:0]    prev_idx;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // compare stage on the data returned by the memory
   assign rd_addr  = issue_ff[IDX_W-1:0];
   assign rd_more  = (issue_ff < count_ff);
   assign hit      = chk_vld_ff && (rd_data_ff == key_ff);
   assign last     = chk_vld_ff && (chk_idx_ff == count_ff - CNT_W'(1));
   assign prev_idx = chk_idx_ff - CNT_W'(1);

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = key_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = cmd_type'(req_tuser);
               key_in   = req_tdata[KEY_BITS-1:0];
               issue_in = '0;
               if (cmd_type'(req_tuser) == CMD_CLEAR) begin
                  count_in      = '0;
                  res_status_in = ST_DONE;
                  res_pos_in    = '0;
                  state_in      = S_FINISH;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end

         S_SEARCH: begin
            if (hit) begin
               // key found at chk_idx_ff
               res_pos_in = chk_idx_ff;
               case (op_ff)
                  CMD_ADD: begin
                     res_status_in = ST_PRESENT;
                     state_in      = S_FINISH;
                  end
                  CMD_DELETE: begin
                     res_status_in = ST_DONE;
                     if (last) begin
                        count_in = count_ff - CNT_W'(1);
                        state_in = S_FINISH;
                     end else begin
                        issue_in = chk_idx_ff + CNT_W'(1);
                        state_in = S_SHIFT;
                     end
                  end
                  default: begin
                     res_status_in = ST_DONE;
                     state_in      = S_FINISH;
                  end
               endcase
            end else if (last || (count_ff == '0)) begin
               // key absent from all held entries
               state_in = S_FINISH;
               if (op_ff == CMD_ADD) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                     res_pos_in    = '0;
                  end else begin
                     wr_en         = 1'b1;
                     res_status_in = ST_DONE;
                     res_pos_in    = count_ff;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end else begin
                  res_status_in = ST_ABSENT;
                  res_pos_in    = '0;
               end
            end else if (rd_more) begin
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff;
               issue_in   = issue_ff + CNT_W'(1);
            end
         end

         S_SHIFT: begin
            // move each later entry down one place
            if (chk_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = prev_idx[IDX_W-1:0];
               wr_data = rd_data_ff;
            end
            if (last) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_FINISH;
            end else if (rd_more) begin
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff;
               issue_in   = issue_ff + CNT_W'(1);
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, COUNT_W'(count_ff),
                               POS_W'(res_pos_ff), res_status_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      issue_ff      <= issue_in;
      chk_idx_ff    <= chk_idx_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

FILE: dv/unordered_key_set_tb.sv
// self-checking testbench for the unordered key set: directed, random and backpressure runs
module unordered_key_set_tb;
   import uks_pkg::*;

   localparam int POOL_SIZE    = 24;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
   localparam int PRINT_LIMIT  = 40;

   typedef struct packed {
      status_type             status;
      logic [POS_W-1:0]       position;
      logic [COUNT_W-1:0]     count;
   } set_reply;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // key[31:0]
   logic [REQ_USER_W-1:0] req_tuser  = '0;  // cmd[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // status[1:0], position[5:2], count[10:6]

   // predictor copy of the set
   logic [KEY_W-1:0]      held_keys [CAPACITY];
   int                    held_count = 0;
   set_reply              predicted_replies [$];

   // run control and bookkeeping
   int                    send_idle = 0;
   int                    recv_idle = 0;
   int                    hold_requests = 0;
   int                    hold_served = 0;
   int                    hold_left = 0;
   int                    stall_cycles = 0;
   int                    mismatches = 0;
   int                    items_sent = 0;
   int                    replies_checked = 0;
   int                    status_seen [4] = '{0, 0, 0, 0};
   logic [KEY_W-1:0]      key_pool [POOL_SIZE];

   unordered_key_set dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // apply one set operation to the predictor copy and return its reply
   function automatic set_reply predict_set_op(cmd_type op, logic [KEY_W-1:0] key);
      set_reply         r;
      logic [KEY_W-1:0] k;
      int               hit;
      r   = '{ST_DONE, '0, '0};
      k   = '0;
      k[KEY_BITS-1:0] = key[KEY_BITS-1:0];
      hit = -1;
      for (int i = 0; i < held_count; i++) begin
         if (hit < 0 && held_keys[i] == k) hit = i;
      end
      case (op)
         CMD_CHECK: begin
            if (hit >= 0) r.position = hit[POS_W-1:0];
            else r.status = ST_ABSENT;
         end
         CMD_ADD: begin
            if (hit >= 0) begin
               r.status   = ST_PRESENT;
               r.position = hit[POS_W-1:0];
            end else if (held_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               held_keys[held_count] = k;
               r.position = held_count[POS_W-1:0];
               held_count++;
            end
         end
         CMD_DELETE: begin
            if (hit >= 0) begin
               // close the gap left by the removed key
               for (int i = hit + 1; i < held_count; i++) held_keys[i-1] = held_keys[i];
               held_count--;
               r.position = hit[POS_W-1:0];
            end else begin
               r.status = ST_ABSENT;
            end
         end
         default: held_count = 0;
      endcase
      r.count = held_count[COUNT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch at %0t: %s got %0d, want %0d", $time, what, got, want);
      mismatches++;
   endtask

   // offer one item, with random gaps, and record its reply at acceptance
   task automatic send_item(cmd_type op, logic [KEY_W-1:0] key);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      predicted_replies.push_back(predict_set_op(op, key));
      items_sent++;
   endtask

   // keys: mostly ones held or from a small pool, so that hits and a full set are common
   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 35 && held_count > 0) return held_keys[$urandom_range(held_count - 1)];
      if (r < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom();
   endfunction

   function automatic cmd_type pick_cmd();
      int r;
      r = $urandom_range(99);
      if (r < 28) return CMD_CHECK;
      if (r < 73) return CMD_ADD;
      if (r < 98) return CMD_DELETE;
      return CMD_CLEAR;
   endfunction

   // extremes of the key, every operation and each corner case
   task automatic test_directed();
      send_item(CMD_CHECK, 32'h0000_0000);    // lookup on an empty set
      send_item(CMD_ADD, 32'h0000_0000);
      send_item(CMD_ADD, 32'hFFFF_FFFF);
      send_item(CMD_ADD, 32'h0000_0000);      // already present
      send_item(CMD_CHECK, 32'hFFFF_FFFF);
      send_item(CMD_DELETE, 32'h0000_0000);   // removal shifts the tail down
      send_item(CMD_DELETE, 32'h0000_0000);   // removal of a missing key
      send_item(CMD_CLEAR, 32'h5A5A_A5A5);
      // fill to capacity with alternating bit patterns
      for (int i = 0; i < CAPACITY; i++)
         send_item(CMD_ADD, ((i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555) ^ i);
      send_item(CMD_ADD, 32'h1234_5678);      // no room left
      send_item(CMD_ADD, 32'hAAAA_AAAA ^ (CAPACITY - 1));  // present while full
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) send_item(pick_cmd(), pick_key());
   endtask

   // receiver stalls for a long stretch while items keep coming
   task automatic test_backpressure();
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < 12; i++) send_item(pick_cmd(), pick_key());
   endtask

   // reply checker and receiver readiness
   always @(posedge clock) begin
      set_reply want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_replies.size() == 0) begin
            report_mismatch("reply with nothing outstanding, status",
                            int'(rsp_tdata[1:0]), -1);
         end else begin
            want = predicted_replies.pop_front();
            if (rsp_tdata[1:0] != want.status)
               report_mismatch("status", int'(rsp_tdata[1:0]), int'(want.status));
            if (rsp_tdata[5:2] != want.position)
               report_mismatch("position", int'(rsp_tdata[5:2]), int'(want.position));
            if (rsp_tdata[10:6] != want.count)
               report_mismatch("count", int'(rsp_tdata[10:6]), int'(want.count));
            status_seen[want.status]++;
            replies_checked++;
         end
      end
      if (hold_served != hold_requests) begin
         hold_left = HOLD_CYCLES;
         hold_served++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
         $display("unordered_key_set verification failed");
         $finish;
      end
   end

   // test sequence
   initial begin
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle = 37;
      recv_idle = 76;
      test_directed();
      test_random(310);

      send_idle = 76;
      recv_idle = 37;
      test_random(310);

      send_idle = 0;
      recv_idle = 0;
      test_backpressure();
      test_random(290);

      req_tvalid <= 1'b0;
      while (predicted_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d items over three idle mixes and one long receiver stall", items_sent);
      $display("checked %0d replies: %0d done, %0d present, %0d full, %0d absent",
               replies_checked, status_seen[ST_DONE], status_seen[ST_PRESENT],
               status_seen[ST_FULL], status_seen[ST_ABSENT]);
      if (mismatches == 0 && predicted_replies.size() == 0) begin
         $display("unordered_key_set verification clean");
      end else begin
         $display("unordered_key_set verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/uks_pkg.sv
hw/rtl/unordered_key_set.sv
dv/unordered_key_set_tb.sv
